### hdl/plsl_pkg.sv
// Shared types and codes for the positional list block.
package plsl_pkg;

  localparam int DEF_CAPACITY = 32;
  localparam int MAX_CAPACITY = 64;
  localparam int POS_W        = $clog2(MAX_CAPACITY + 1);
  localparam int DATA_W       = 32;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6,
    OP_NOP       = 3'd7
  } plsl_op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } plsl_status_t;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ROT  = 2'd3
  } plsl_kind_t;

  typedef struct packed {
    plsl_op_t                  op;
    logic signed [DATA_W-1:0]  value;
    logic        [7:0]         position;
  } plsl_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  element;
    logic        [5:0]         length;
    plsl_status_t              status;
    logic                      last;
  } plsl_out_t;

  typedef struct packed {
    plsl_kind_t                kind;
    logic        [POS_W-1:0]   at;
    logic        [POS_W-1:0]   cnt;
    logic signed [DATA_W-1:0]  value;
  } plsl_cmd_t;

endpackage

### hdl/plsl_cell.sv
// One storage cell of the shifting list row.
module plsl_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  plsl_pkg::plsl_cmd_t               cmd,
  input  logic signed [plsl_pkg::DATA_W-1:0] left_val,
  input  logic signed [plsl_pkg::DATA_W-1:0] right_val,
  input  logic signed [plsl_pkg::DATA_W-1:0] head_val,
  output logic signed [plsl_pkg::DATA_W-1:0] val
);
  import plsl_pkg::*;

  localparam logic [POS_W-1:0] IDX      = POS_W'(INDEX);
  localparam logic [POS_W-1:0] IDX_NEXT = POS_W'(INDEX + 1);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (cmd.kind)
      CMD_INS: begin
        if (IDX == cmd.at) begin
          val_nxt = cmd.value;
        end else if (IDX > cmd.at) begin
          val_nxt = left_val;
        end
      end
      CMD_DEL: begin
        if (IDX >= cmd.at) begin
          val_nxt = right_val;
        end
      end
      CMD_ROT: begin
        if (IDX_NEXT == cmd.cnt) begin
          val_nxt = head_val;
        end else if (IDX_NEXT < cmd.cnt) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

### hdl/positional_list_insert_delete_top.sv
// Bounded positional list: a row of shifting cells with a small controller.
// Insert and delete items are taken in any cycle in which busy is low; a
// valid one shifts the row at the accepting edge, and the single result
// shows on out_item with out_valid high in the following cycle. A dump of
// a list holding N entries raises busy once accepted and produces N results
// on consecutive cycles, front to back, each read from the front cell into
// the output register in the dump state; the row rotates one cell per cycle
// and is back in order when the last one leaves, and busy then falls.
// An empty dump and every other op give one result and keep busy low.
// The receiver cannot stall: each result is present for exactly one cycle.
module positional_list_insert_delete_top #(
  parameter int CAPACITY = plsl_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plsl_pkg::plsl_in_t  in_item,
  output logic                out_valid,
  output plsl_pkg::plsl_out_t out_item
);
  import plsl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;
  logic                     out_valid_r, out_valid_nxt;
  plsl_out_t                out_r, out_nxt;
  plsl_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_val [CAPACITY];

  logic [8:0]               pos9;
  logic [8:0]               cnt9;
  logic                     full;
  logic                     empty;
  plsl_status_t             st;

  assign pos9  = {1'b0, in_item.position};
  assign cnt9  = 9'(count_r);
  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd.kind      = CMD_HOLD;
    cmd.at        = '0;
    cmd.cnt       = POS_W'(count_r);
    cmd.value     = in_item.value;
    st            = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_item.op) inside
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
              if (in_item.op == OP_INS_AT && (pos9 == 9'd0 || pos9 > cnt9 + 9'd1)) begin
                st = ST_BADPOS;
              end else if (full) begin
                st = ST_FULL;
              end else begin
                cmd.kind  = CMD_INS;
                count_nxt = count_r + CW'(1);
                if (in_item.op == OP_INS_FIRST) begin
                  cmd.at = '0;
                end else if (in_item.op == OP_INS_LAST) begin
                  cmd.at = POS_W'(count_r);
                end else begin
                  cmd.at = POS_W'(in_item.position - 8'd1);
                end
              end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
              if (empty) begin
                st = ST_EMPTY;
              end else if (in_item.op == OP_DEL_AT && (pos9 == 9'd0 || pos9 > cnt9)) begin
                st = ST_BADPOS;
              end else begin
                cmd.kind  = CMD_DEL;
                count_nxt = count_r - CW'(1);
                if (in_item.op == OP_DEL_FIRST) begin
                  cmd.at = '0;
                end else if (in_item.op == OP_DEL_LAST) begin
                  cmd.at = POS_W'(count_r - CW'(1));
                end else begin
                  cmd.at = POS_W'(in_item.position - 8'd1);
                end
              end
            end
            OP_DUMP: begin
              if (!empty) begin
                state_nxt = S_DUMP;
                rem_nxt   = count_r;
              end
            end
            OP_NOP: st = ST_OK;
            default: st = ST_OK;
          endcase
          if (!(in_item.op == OP_DUMP && !empty)) begin
            out_valid_nxt  = 1'b1;
            out_nxt.element = '0;
            out_nxt.length = 6'(count_nxt);
            out_nxt.status = st;
            out_nxt.last   = 1'b1;
          end
        end
      end
      S_DUMP: begin
        cmd.kind        = CMD_ROT;
        out_valid_nxt   = 1'b1;
        out_nxt.element = cell_val[0];
        out_nxt.length  = 6'(count_r);
        out_nxt.status  = ST_OK;
        out_nxt.last    = (rem_r == CW'(1));
        rem_nxt         = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plsl_cell #(
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_val  (cell_val[(i == 0) ? 0 : i - 1]),
      .right_val (cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .head_val  (cell_val[0]),
      .val       (cell_val[i])
    );
  end

  assign busy      = (state_r == S_DUMP);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### hdl/plsl_check.sv
// Port-level checks for the positional list block, bound to the top level.
module plsl_check (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input plsl_pkg::plsl_out_t out_item
);
  import plsl_pkg::*;

  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted item produced neither a result nor a dump");

  a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid)
    else $error("dump stream broken before its last item");

  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("non-final dump item while not busy");

  a_error_no_element: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.element == '0)
    else $error("error result carries an element");

  a_dump_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && !$past(out_item.last)
      |-> out_item.length == $past(out_item.length))
    else $error("length changed during dump");

endmodule

bind positional_list_insert_delete_top plsl_check u_plsl_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
